/* sv/sgi_pkg.sv */
package sgi_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int LEN_W   = PROD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [LEN_W-1:0]   len_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    point_t a_start;
    point_t a_end;
    point_t b_start;
    point_t b_end;
  } seg_pair_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  // direction vectors of both segments and the endpoint offsets seen from each start
  typedef struct packed {
    vec_t ua;
    vec_t ub;
    vec_t v1;
    vec_t v2;
    vec_t v3;
    vec_t v4;
  } diff_set_t;

  typedef struct packed {
    prod_t lhs;
    prod_t rhs;
    logic  behind;
    prod_t sq_ux;
    prod_t sq_uy;
    prod_t sq_vx;
    prod_t sq_vy;
  } ori_prod_t;

  typedef struct packed {
    ori_prod_t o1;
    ori_prod_t o2;
    ori_prod_t o3;
    ori_prod_t o4;
  } prod_set_t;

  typedef enum logic [1:0] {
    ORI_NEG,
    ORI_ZERO,
    ORI_POS
  } orient_e;

endpackage

/* sv/segment_intersection_test.sv */
// an accepted pair passes the difference, product and orientation registers into the output register
// throughput: one segment pair per cycle while the output is not stalled, set by the four-stage pipeline
// (differences, products, orientation compare, output register)
// a stall on the output freezes the stages behind it; bubbles are squeezed out
// reset clears every valid bit; payload registers keep whatever they hold
module segment_intersection_test
  import sgi_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  coord_t a_start_x_i,
  input  coord_t a_start_y_i,
  input  coord_t a_end_x_i,
  input  coord_t a_end_y_i,
  input  coord_t b_start_x_i,
  input  coord_t b_start_y_i,
  input  coord_t b_end_x_i,
  input  coord_t b_end_y_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output logic   intersects_o
);

  function automatic logic straddles(orient_e a, orient_e b);
    return (a == ORI_ZERO) || (b == ORI_ZERO) || (a != b);
  endfunction

  seg_pair_t pair;
  diff_set_t diff;
  prod_set_t prod;
  orient_e   ori1, ori2, ori3, ori4;
  orient_e   ori1_q, ori2_q, ori3_q, ori4_q;
  logic      v1_q, v2_q, v3_q, out_valid_q;
  logic      en1, en2, en3, en_out;
  logic      hit_d, hit_q;

  assign en_out     = !out_valid_q || !out_stall_i;
  assign en3        = !v3_q || en_out;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  always_comb begin
    pair.a_start.x = a_start_x_i;
    pair.a_start.y = a_start_y_i;
    pair.a_end.x   = a_end_x_i;
    pair.a_end.y   = a_end_y_i;
    pair.b_start.x = b_start_x_i;
    pair.b_start.y = b_start_y_i;
    pair.b_end.x   = b_end_x_i;
    pair.b_end.y   = b_end_y_i;
  end

  sgi_diff u_diff (
    .clk_i  (clk_i),
    .en_i   (en1),
    .pair_i (pair),
    .diff_o (diff)
  );

  sgi_prod u_prod (
    .clk_i  (clk_i),
    .en_i   (en2),
    .diff_i (diff),
    .prod_o (prod)
  );

  sgi_orient u_ori1 (.prod_i(prod.o1), .ori_o(ori1));
  sgi_orient u_ori2 (.prod_i(prod.o2), .ori_o(ori2));
  sgi_orient u_ori3 (.prod_i(prod.o3), .ori_o(ori3));
  sgi_orient u_ori4 (.prod_i(prod.o4), .ori_o(ori4));

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ori1_q <= ori1;
      ori2_q <= ori2;
      ori3_q <= ori3;
      ori4_q <= ori4;
    end
  end

  assign hit_d = straddles(ori1_q, ori2_q) && straddles(ori3_q, ori4_q);

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign intersects_o = hit_q;

endmodule

/* sv/sgi_diff.sv */
module sgi_diff
  import sgi_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  seg_pair_t pair_i,
  output diff_set_t diff_o
);

  function automatic vec_t vsub(point_t p, point_t q);
    vec_t r;
    r.x = diff_t'(p.x) - diff_t'(q.x);
    r.y = diff_t'(p.y) - diff_t'(q.y);
    return r;
  endfunction

  diff_set_t diff_d, diff_q;

  always_comb begin
    diff_d.ua = vsub(pair_i.a_end,   pair_i.a_start);
    diff_d.ub = vsub(pair_i.b_end,   pair_i.b_start);
    diff_d.v1 = vsub(pair_i.b_start, pair_i.a_start);
    diff_d.v2 = vsub(pair_i.b_end,   pair_i.a_start);
    diff_d.v3 = vsub(pair_i.a_start, pair_i.b_start);
    diff_d.v4 = vsub(pair_i.a_end,   pair_i.b_start);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
    end
  end

  assign diff_o = diff_q;

endmodule

/* sv/sgi_prod.sv */
module sgi_prod
  import sgi_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  diff_set_t diff_i,
  output prod_set_t prod_o
);

  function automatic prod_t mul(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // true when the product of a and b is negative
  function automatic logic opposite(diff_t a, diff_t b);
    return (a != '0) && (b != '0) && (a[DIFF_W-1] != b[DIFF_W-1]);
  endfunction

  prod_t     sq_ua_x, sq_ua_y, sq_ub_x, sq_ub_y;
  prod_t     sq_v1_x, sq_v1_y, sq_v2_x, sq_v2_y, sq_v4_x, sq_v4_y;
  prod_set_t prod_d, prod_q;

  always_comb begin
    sq_ua_x = mul(diff_i.ua.x, diff_i.ua.x);
    sq_ua_y = mul(diff_i.ua.y, diff_i.ua.y);
    sq_ub_x = mul(diff_i.ub.x, diff_i.ub.x);
    sq_ub_y = mul(diff_i.ub.y, diff_i.ub.y);
    sq_v1_x = mul(diff_i.v1.x, diff_i.v1.x);
    sq_v1_y = mul(diff_i.v1.y, diff_i.v1.y);
    sq_v2_x = mul(diff_i.v2.x, diff_i.v2.x);
    sq_v2_y = mul(diff_i.v2.y, diff_i.v2.y);
    sq_v4_x = mul(diff_i.v4.x, diff_i.v4.x);
    sq_v4_y = mul(diff_i.v4.y, diff_i.v4.y);

    prod_d.o1.lhs    = mul(diff_i.ua.x, diff_i.v1.y);
    prod_d.o1.rhs    = mul(diff_i.ua.y, diff_i.v1.x);
    prod_d.o1.behind = opposite(diff_i.ua.x, diff_i.v1.x) |
                       opposite(diff_i.ua.y, diff_i.v1.y);
    prod_d.o1.sq_ux  = sq_ua_x;
    prod_d.o1.sq_uy  = sq_ua_y;
    prod_d.o1.sq_vx  = sq_v1_x;
    prod_d.o1.sq_vy  = sq_v1_y;

    prod_d.o2.lhs    = mul(diff_i.ua.x, diff_i.v2.y);
    prod_d.o2.rhs    = mul(diff_i.ua.y, diff_i.v2.x);
    prod_d.o2.behind = opposite(diff_i.ua.x, diff_i.v2.x) |
                       opposite(diff_i.ua.y, diff_i.v2.y);
    prod_d.o2.sq_ux  = sq_ua_x;
    prod_d.o2.sq_uy  = sq_ua_y;
    prod_d.o2.sq_vx  = sq_v2_x;
    prod_d.o2.sq_vy  = sq_v2_y;

    // v3 is -v1, so its squares are shared
    prod_d.o3.lhs    = mul(diff_i.ub.x, diff_i.v3.y);
    prod_d.o3.rhs    = mul(diff_i.ub.y, diff_i.v3.x);
    prod_d.o3.behind = opposite(diff_i.ub.x, diff_i.v3.x) |
                       opposite(diff_i.ub.y, diff_i.v3.y);
    prod_d.o3.sq_ux  = sq_ub_x;
    prod_d.o3.sq_uy  = sq_ub_y;
    prod_d.o3.sq_vx  = sq_v1_x;
    prod_d.o3.sq_vy  = sq_v1_y;

    prod_d.o4.lhs    = mul(diff_i.ub.x, diff_i.v4.y);
    prod_d.o4.rhs    = mul(diff_i.ub.y, diff_i.v4.x);
    prod_d.o4.behind = opposite(diff_i.ub.x, diff_i.v4.x) |
                       opposite(diff_i.ub.y, diff_i.v4.y);
    prod_d.o4.sq_ux  = sq_ub_x;
    prod_d.o4.sq_uy  = sq_ub_y;
    prod_d.o4.sq_vx  = sq_v4_x;
    prod_d.o4.sq_vy  = sq_v4_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* sv/sgi_orient.sv */
module sgi_orient
  import sgi_pkg::*;
(
  input  ori_prod_t prod_i,
  output orient_e   ori_o
);

  len_t len_u, len_v;

  assign len_u = LEN_W'($unsigned(prod_i.sq_ux)) + LEN_W'($unsigned(prod_i.sq_uy));
  assign len_v = LEN_W'($unsigned(prod_i.sq_vx)) + LEN_W'($unsigned(prod_i.sq_vy));

  always_comb begin
    if (prod_i.lhs > prod_i.rhs) begin
      ori_o = ORI_POS;
    end else if (prod_i.lhs < prod_i.rhs) begin
      ori_o = ORI_NEG;
    end else if (prod_i.behind) begin
      ori_o = ORI_NEG;
    end else if (len_u >= len_v) begin
      ori_o = ORI_ZERO;
    end else begin
      ori_o = ORI_POS;
    end
  end

endmodule

/* sv/sgi_assert.sv */
module sgi_assert
  import sgi_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_stall_o,
  input coord_t a_start_x_i,
  input coord_t a_start_y_i,
  input coord_t b_start_x_i,
  input coord_t b_start_y_i,
  input logic   out_valid_o,
  input logic   out_stall_i,
  input logic   intersects_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(intersects_o))
    else $error("stalled result beat changed");

  // no output stall means the input side is never stalled
  a_no_backpressure: assert property (@(posedge clk_i)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without output stall");

  // segments sharing a start point always intersect; checked once the pair has passed the pipeline unstalled
  a_shared_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && a_start_x_i == b_start_x_i && a_start_y_i == b_start_y_i)
    ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o && intersects_o)
    else $error("shared start point not reported as intersecting");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind segment_intersection_test sgi_assert u_sgi_assert (.*);
